[rtl/wchp_pkg.sv]
// constants and register codes for the wire chamber hit position pipeline
package wchp_pkg;

	localparam int NumAxes = 4;
	localparam int CntW    = 16;
	localparam int DiffW   = CntW + 1;
	localparam int SlopeW  = 32;
	localparam int BaseW   = 24;
	localparam int PosW    = 24;
	localparam int ThrW    = 23;
	localparam int CfgW    = 32;
	localparam int ProdW   = DiffW + SlopeW;
	localparam int MagW    = ProdW - 1;

	// divide by 10240 = 2^11 * 5, rounded half away from zero
	localparam int                RoundShift = 11;
	localparam logic [MagW:0]     RoundHalf  = (MagW + 1)'(5120);
	localparam int                TW         = 28;
	localparam logic [TW-1:0]     TClamp     = TW'(5 * (2 ** 25) - 1);
	localparam int                RecipW     = 29;
	localparam logic [RecipW-1:0] Recip      = RecipW'(429496730);
	localparam int                RecipShift = 31;
	localparam int                QW         = 25;

	localparam int SumW = QW + 2;
	localparam int SqW  = 2 * PosW - 1;
	localparam int AdW  = PosW + 1;

	localparam logic signed [SumW-1:0] PosMax = SumW'(8388607);
	localparam logic signed [SumW-1:0] PosMin = -SumW'(8388608);

	localparam logic [SlopeW-1:0] SlopeReset = SlopeW'(65536);
	localparam int DefVetoRadius = 20;

	localparam int AxX1 = 0;
	localparam int AxY1 = 1;
	localparam int AxX2 = 2;
	localparam int AxY2 = 3;

	typedef enum logic [2:0] {
		REG_SLOPE_X1 = 3'd0,
		REG_SLOPE_Y1 = 3'd1,
		REG_SLOPE_X2 = 3'd2,
		REG_SLOPE_Y2 = 3'd3,
		REG_BASE_X1  = 3'd4,
		REG_BASE_Y1  = 3'd5,
		REG_BASE_X2  = 3'd6,
		REG_BASE_Y2  = 3'd7
	} reg_idx_t;

endpackage

[rtl/wire_chamber_hit_position.sv]
// wire chamber hit position: eight-stage pipeline from timing counts to centred positions
//
// usage:
//   input channel carries one event per transaction: eight 16-bit timing counts
//   and an alignment threshold; output channel returns four saturated
//   beam-centred positions in 1/256 mm plus veto and alignment flags
//   one event may be accepted every cycle while in_stall is low; the path from
//   input transaction to out_valid is the stage chain: difference, slope
//   multiply, magnitude, round and clamp, reciprocal multiply for the divide
//   by 5, base add with saturation, squares and distances, and the final compares
//   each stage holds only while the stage after it is full and held, so a
//   stalled output fills bubbles first and in_stall rises only when all
//   eight stages are occupied
//   configuration: cfg_write with cfg_index and cfg_data sets a slope or base
//   register; write only while the pipeline is empty
//   reset clears all valid bits and loads slopes with 1.0 and bases with 0
module wire_chamber_hit_position #(
	parameter int VETO_RADIUS = wchp_pkg::DefVetoRadius
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [2:0]                        cfg_index,
	input  logic [wchp_pkg::CfgW-1:0]         cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [wchp_pkg::CntW-1:0]         c1_x_a,
	input  logic [wchp_pkg::CntW-1:0]         c1_x_b,
	input  logic [wchp_pkg::CntW-1:0]         c1_y_a,
	input  logic [wchp_pkg::CntW-1:0]         c1_y_b,
	input  logic [wchp_pkg::CntW-1:0]         c2_x_a,
	input  logic [wchp_pkg::CntW-1:0]         c2_x_b,
	input  logic [wchp_pkg::CntW-1:0]         c2_y_a,
	input  logic [wchp_pkg::CntW-1:0]         c2_y_b,
	input  logic [wchp_pkg::ThrW-1:0]         align_threshold,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [wchp_pkg::PosW-1:0]  pos_x1,
	output logic signed [wchp_pkg::PosW-1:0]  pos_y1,
	output logic signed [wchp_pkg::PosW-1:0]  pos_x2,
	output logic signed [wchp_pkg::PosW-1:0]  pos_y2,
	output logic                              in_veto,
	output logic                              in_align
);
	import wchp_pkg::*;

	localparam logic [63:0] VetoR  = 64'(VETO_RADIUS) * 64'd256;
	localparam logic [63:0] VetoR2 = VetoR * VetoR;

	logic signed [SlopeW-1:0] slope_q [NumAxes];
	logic signed [BaseW-1:0]  base_q  [NumAxes];

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6, en_s7, en_s8;

	logic signed [DiffW-1:0]  d_s1    [NumAxes];
	logic signed [ProdW-1:0]  prod_s2 [NumAxes];
	logic [MagW-1:0]          mag_s3  [NumAxes];
	logic [TW-1:0]            t_s4    [NumAxes];
	logic [QW-1:0]            q_s5    [NumAxes];
	logic signed [PosW-1:0]   pos_s6  [NumAxes];
	logic signed [PosW-1:0]   pos_s7  [NumAxes];
	logic [SqW-1:0]           sq_s7   [NumAxes];
	logic [AdW-1:0]           adx_s7, ady_s7;
	logic signed [PosW-1:0]   pos_s8  [NumAxes];
	logic                     veto_s8, align_s8;

	logic [NumAxes-1:0]       neg_s3, neg_s4, neg_s5;
	logic [ThrW-1:0]          thr_s1, thr_s2, thr_s3, thr_s4, thr_s5, thr_s6, thr_s7;

	logic [CntW-1:0]          cnt_a [NumAxes];
	logic [CntW-1:0]          cnt_b [NumAxes];
	logic [NumAxes-1:0]       horiz;

	// stage enables: a stage moves when it is empty or the next one moves
	assign en_s8    = !vld_s8 || !out_stall;
	assign en_s7    = !vld_s7 || en_s8;
	assign en_s6    = !vld_s6 || en_s7;
	assign en_s5    = !vld_s5 || en_s6;
	assign en_s4    = !vld_s4 || en_s5;
	assign en_s3    = !vld_s3 || en_s4;
	assign en_s2    = !vld_s2 || en_s3;
	assign en_s1    = !vld_s1 || en_s2;
	assign in_stall = !en_s1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NumAxes; i++) begin
				slope_q[i] <= SlopeReset;
				base_q[i]  <= '0;
			end
		end else if (cfg_write) begin
			unique case (reg_idx_t'(cfg_index))
				REG_SLOPE_X1: slope_q[AxX1] <= cfg_data;
				REG_SLOPE_Y1: slope_q[AxY1] <= cfg_data;
				REG_SLOPE_X2: slope_q[AxX2] <= cfg_data;
				REG_SLOPE_Y2: slope_q[AxY2] <= cfg_data;
				REG_BASE_X1:  base_q[AxX1]  <= cfg_data[BaseW-1:0];
				REG_BASE_Y1:  base_q[AxY1]  <= cfg_data[BaseW-1:0];
				REG_BASE_X2:  base_q[AxX2]  <= cfg_data[BaseW-1:0];
				REG_BASE_Y2:  base_q[AxY2]  <= cfg_data[BaseW-1:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else begin
			if (en_s1) vld_s1 <= in_valid;
			if (en_s2) vld_s2 <= vld_s1;
			if (en_s3) vld_s3 <= vld_s2;
			if (en_s4) vld_s4 <= vld_s3;
			if (en_s5) vld_s5 <= vld_s4;
			if (en_s6) vld_s6 <= vld_s5;
			if (en_s7) vld_s7 <= vld_s6;
			if (en_s8) vld_s8 <= vld_s7;
		end
	end

	always_comb begin
		cnt_a[AxX1] = c1_x_a;
		cnt_b[AxX1] = c1_x_b;
		cnt_a[AxY1] = c1_y_a;
		cnt_b[AxY1] = c1_y_b;
		cnt_a[AxX2] = c2_x_a;
		cnt_b[AxX2] = c2_x_b;
		cnt_a[AxY2] = c2_y_a;
		cnt_b[AxY2] = c2_y_b;
		horiz       = '0;
		horiz[AxX1] = 1'b1;
		horiz[AxX2] = 1'b1;
	end

	// s1: count difference, horizontal axes negated
	always_ff @(posedge clk) begin
		if (en_s1) begin
			for (int i = 0; i < NumAxes; i++) begin
				if (horiz[i])
					d_s1[i] <= $signed({1'b0, cnt_b[i]}) - $signed({1'b0, cnt_a[i]});
				else
					d_s1[i] <= $signed({1'b0, cnt_a[i]}) - $signed({1'b0, cnt_b[i]});
			end
			thr_s1 <= align_threshold;
		end
	end

	// s2: slope multiply
	always_ff @(posedge clk) begin
		if (en_s2) begin
			for (int i = 0; i < NumAxes; i++)
				prod_s2[i] <= ProdW'(d_s1[i]) * ProdW'(slope_q[i]);
			thr_s2 <= thr_s1;
		end
	end

	// s3: sign and magnitude
	always_ff @(posedge clk) begin
		if (en_s3) begin
			for (int i = 0; i < NumAxes; i++) begin
				neg_s3[i] <= prod_s2[i][ProdW-1];
				mag_s3[i] <= prod_s2[i][ProdW-1] ? MagW'(-prod_s2[i]) : prod_s2[i][MagW-1:0];
			end
			thr_s3 <= thr_s2;
		end
	end

	// s4: add half, drop the power of two, clamp far beyond the output range
	always_ff @(posedge clk) begin
		if (en_s4) begin
			for (int i = 0; i < NumAxes; i++) begin
				logic [MagW:0] rnd;
				logic [MagW-RoundShift:0] tw;
				rnd = {1'b0, mag_s3[i]} + RoundHalf;
				tw  = rnd[MagW:RoundShift];
				t_s4[i] <= (tw > (MagW - RoundShift + 1)'(TClamp)) ? TClamp : tw[TW-1:0];
			end
			neg_s4 <= neg_s3;
			thr_s4 <= thr_s3;
		end
	end

	// s5: divide by five through reciprocal multiply
	always_ff @(posedge clk) begin
		if (en_s5) begin
			for (int i = 0; i < NumAxes; i++) begin
				logic [TW+RecipW-1:0] rp;
				rp = (TW + RecipW)'(t_s4[i]) * (TW + RecipW)'(Recip);
				q_s5[i] <= rp[RecipShift+QW-1:RecipShift];
			end
			neg_s5 <= neg_s4;
			thr_s5 <= thr_s4;
		end
	end

	// s6: restore sign, add base, saturate
	always_ff @(posedge clk) begin
		if (en_s6) begin
			for (int i = 0; i < NumAxes; i++) begin
				logic signed [SumW-1:0] sq;
				logic signed [SumW-1:0] sum;
				sq  = neg_s5[i] ? -$signed(SumW'(q_s5[i])) : $signed(SumW'(q_s5[i]));
				sum = sq + SumW'(base_q[i]);
				priority if (sum > PosMax)
					pos_s6[i] <= PosMax[PosW-1:0];
				else if (sum < PosMin)
					pos_s6[i] <= PosMin[PosW-1:0];
				else
					pos_s6[i] <= sum[PosW-1:0];
			end
			thr_s6 <= thr_s5;
		end
	end

	// s7: squares and chamber-to-chamber distances
	always_ff @(posedge clk) begin
		if (en_s7) begin
			logic signed [AdW-1:0] dx, dy;
			dx = AdW'(pos_s6[AxX1]) - AdW'(pos_s6[AxX2]);
			dy = AdW'(pos_s6[AxY1]) - AdW'(pos_s6[AxY2]);
			for (int i = 0; i < NumAxes; i++) begin
				logic signed [2*PosW-1:0] sqr;
				sqr = (2 * PosW)'(pos_s6[i]) * (2 * PosW)'(pos_s6[i]);
				sq_s7[i]  <= sqr[SqW-1:0];
				pos_s7[i] <= pos_s6[i];
			end
			adx_s7 <= dx[AdW-1] ? AdW'(-dx) : dx;
			ady_s7 <= dy[AdW-1] ? AdW'(-dy) : dy;
			thr_s7 <= thr_s6;
		end
	end

	// s8: veto radius and alignment compares
	always_ff @(posedge clk) begin
		if (en_s8) begin
			logic [SqW:0] r1, r2;
			r1 = {1'b0, sq_s7[AxX1]} + {1'b0, sq_s7[AxY1]};
			r2 = {1'b0, sq_s7[AxX2]} + {1'b0, sq_s7[AxY2]};
			veto_s8  <= (64'(r1) < VetoR2) && (64'(r2) < VetoR2);
			align_s8 <= (adx_s7 < AdW'(thr_s7)) && (ady_s7 < AdW'(thr_s7));
			for (int i = 0; i < NumAxes; i++)
				pos_s8[i] <= pos_s7[i];
		end
	end

	assign out_valid = vld_s8;
	assign pos_x1    = pos_s8[AxX1];
	assign pos_y1    = pos_s8[AxY1];
	assign pos_x2    = pos_s8[AxX2];
	assign pos_y2    = pos_s8[AxY2];
	assign in_veto   = veto_s8;
	assign in_align  = align_s8;

endmodule
